[sv/upd_pkg.sv]
// upd_pkg: types, character constants and the hex nibble function for the
// URL percent decoder. No dependencies.
package upd_pkg;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] HEX_TEN    = 8'd10;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_present;
      logic       out_last;
   } rsp_beat_type;

   // decode result for one input beat
   typedef struct packed {
      logic         emit;
      rsp_beat_type rsp;
   } dec_type;

   // unchecked hex digit: letters are folded to lowercase, anything else wraps
   function automatic logic [7:0] hex_nibble(input logic [7:0] c);
      logic [7:0] lc;
      lc = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         lc = c | CASE_BIT;
      end
      if (c >= CH_ZERO && c <= CH_NINE) begin
         return c - CH_ZERO;
      end
      return lc + HEX_TEN - CH_LOWER_A;
   endfunction

endpackage

[sv/upd_stream_if.sv]
// Valid/ready channel interfaces for the URL percent decoder.
// Depends on nothing; payload fields carry the beat fields by name.
interface upd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_present;
   logic       out_last;

   modport source (output valid, output out_byte, output out_present,
                   output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_present,
                   input out_last, output ready);
endinterface

[sv/upd_in_stage.sv]
// Input register stage of the URL percent decoder.
// Depends on upd_pkg.
module upd_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  upd_pkg::req_beat_type req_beat,
   input  logic                 take,
   output logic                 s1_valid,
   output upd_pkg::req_beat_type s1_beat
);
   import upd_pkg::*;

   logic         valid_ff, valid_in;
   req_beat_type beat_ff, beat_in;

   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      beat_in  = beat_ff;
      if (req_ready) begin
         valid_in = req_valid;
         beat_in  = req_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign s1_valid = valid_ff;
   assign s1_beat  = beat_ff;

endmodule

[sv/upd_decode.sv]
// Escape state and per-beat decode of the URL percent decoder.
// Depends on upd_pkg (types, constants, hex_nibble).
module upd_decode (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  upd_pkg::req_beat_type beat,
   output upd_pkg::dec_type     dec
);
   import upd_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [7:0] first_ff, first_in;
   logic [7:0] plain;
   logic [7:0] hi_nib;
   logic [7:0] lo_nib;
   logic [7:0] pair;

   // plus maps to space, everything else passes
   assign plain  = (beat.in_byte == CH_PLUS) ? CH_SPACE : beat.in_byte;
   assign hi_nib = hex_nibble(first_ff);
   assign lo_nib = hex_nibble(beat.in_byte);
   assign pair   = {hi_nib[3:0], 4'h0} | lo_nib;

   always_comb begin
      phase_in = PH_IDLE;
      first_in = 8'h00;
      dec      = '0;
      case (phase_ff)
         PH_DIGIT: begin
            dec.emit            = 1'b1;
            dec.rsp.out_byte    = pair;
            dec.rsp.out_present = 1'b1;
            dec.rsp.out_last    = beat.in_last;
         end
         PH_PERCENT: begin
            if (!beat.in_last) begin
               phase_in = PH_DIGIT;
               first_in = beat.in_byte;
            end else begin
               // dangling percent dropped; final byte decoded alone unless it is a percent
               dec.emit         = 1'b1;
               dec.rsp.out_last = 1'b1;
               if (beat.in_byte != CH_PERCENT) begin
                  dec.rsp.out_byte    = plain;
                  dec.rsp.out_present = 1'b1;
               end
            end
         end
         default: begin
            if (beat.in_byte == CH_PERCENT) begin
               if (beat.in_last) begin
                  dec.emit         = 1'b1;
                  dec.rsp.out_last = 1'b1;
               end else begin
                  phase_in = PH_PERCENT;
               end
            end else begin
               dec.emit            = 1'b1;
               dec.rsp.out_byte    = plain;
               dec.rsp.out_present = 1'b1;
               dec.rsp.out_last    = beat.in_last;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         first_ff <= 8'h00;
      end else if (step) begin
         phase_ff <= phase_in;
         first_ff <= first_in;
      end
   end

endmodule

[sv/url_percent_decoder.sv]
// Top level of the URL percent decoder: input register, decode, result register.
// Depends on upd_pkg, upd_stream_if, upd_in_stage and upd_decode.
//
//   channel   dir  beat fields                           beats
//   req_chan  in   in_byte, in_last                      one encoded char
//   rsp_chan  out  out_byte, out_present, out_last       zero or one per char
//
// One char per cycle sustained unless rsp stalls; a req beat reaches rsp via the
// input register, then the result register (decode is a single short level).
// A percent and its first digit give no rsp beat; a final char always gives one.
// Synchronous reset clears the valid flags and the escape state.
// A stalled rsp beat holds and backs up through the input register to req ready.
module url_percent_decoder (
   input  logic      clock,
   input  logic      reset,
   upd_req_if.sink   req_chan,
   upd_rsp_if.source rsp_chan
);
   import upd_pkg::*;

   logic         s1_valid;
   req_beat_type s1_beat;
   req_beat_type req_beat;
   logic         out_free;
   logic         step;
   dec_type      dec;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   assign req_beat.in_byte = req_chan.in_byte;
   assign req_beat.in_last = req_chan.in_last;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign step     = s1_valid && out_free;

   upd_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .req_beat  (req_beat),
      .take      (step),
      .s1_valid  (s1_valid),
      .s1_beat   (s1_beat)
   );

   upd_decode u_dec (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .beat  (s1_beat),
      .dec   (dec)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_free) begin
         rsp_valid_in = step && dec.emit;
         rsp_beat_in  = dec.rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_beat_ff.out_byte;
   assign rsp_chan.out_present = rsp_beat_ff.out_present;
   assign rsp_chan.out_last    = rsp_beat_ff.out_last;

endmodule

[sv/upd_checker.sv]
// Port-level checks for url_percent_decoder, bound to the top level.
// Depends only on the top level's channel signals.
module upd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_byte,
   input logic       rsp_present,
   input logic       rsp_last
);

   // an empty result carries a zero byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_byte == 8'h00)
      else $error("empty rsp beat with nonzero byte");

   // only a dropped escape at the end of a string gives an empty result
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_present |-> rsp_last)
      else $error("empty rsp beat not marked last");

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a final char taken with no rsp beat pending comes out as a rsp beat
   a_last_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last && !rsp_valid ##1 !reset && rsp_ready
      |=> rsp_valid)
      else $error("final char did not produce a rsp beat");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_last))
      else $error("stalled rsp beat changed");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_last    (req_chan.in_last),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_byte    (rsp_chan.out_byte),
   .rsp_present (rsp_chan.out_present),
   .rsp_last    (rsp_chan.out_last)
);
